// ----- design/slcd_pkg.sv -----
// Shared types, command codes and the glyph table for the segment LCD text encoder.
// Used by design/segment_lcd_text_encoder_core.sv; depends on nothing else.
package slcd_pkg;

    localparam int DIGITS_DEFAULT = 5;
    localparam int MAX_RESULTS    = 6;

    localparam logic [2:0] CMD_CHAR   = 3'd0;
    localparam logic [2:0] CMD_SET    = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_TOGGLE = 3'd3;
    localparam logic [2:0] CMD_FILL   = 3'd4;

    localparam logic [7:0] COLON_BIT = 8'h10;
    localparam logic [7:0] POINT_BIT = 8'h20;
    localparam logic [7:0] ALL_ON    = 8'hFF;

    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_Z     = 8'd90;
    localparam logic [7:0] CHAR_LOW_A = 8'd97;
    localparam logic [7:0] CHAR_LOW_Z = 8'd122;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_DOT   = 8'd46;
    localparam logic [7:0] CHAR_COLON = 8'd58;

    typedef struct packed {
        logic [7:0] indicator_bits;
        logic [2:0] next_digit;
        logic       minus_pending;
        logic       point_pending;
    } state_t;

    localparam state_t STATE_RESET = '{
        indicator_bits: 8'h00, next_digit: 3'd1, minus_pending: 1'b0, point_pending: 1'b0
    };

    localparam logic [7:0] GLYPH_TABLE [59] = '{
        8'h00, 8'h2C, 8'h48, 8'hCA, 8'h55, 8'h44, 8'hD8, 8'h08,
        8'hD1, 8'h8D, 8'h00, 8'h52, 8'h04, 8'h02, 8'h20, 8'h0C,
        8'hDD, 8'h0C, 8'h9B, 8'h8F, 8'h4E, 8'hC7, 8'hD7, 8'hCC,
        8'hDF, 8'hCF, 8'h00, 8'h40, 8'h11, 8'h03, 8'h05, 8'h9A,
        8'hFF, 8'hDE, 8'h57, 8'h13, 8'h1F, 8'hD3, 8'hD2, 8'hCF,
        8'h56, 8'h10, 8'h1D, 8'hD6, 8'h51, 8'hDC, 8'h16, 8'h17,
        8'hDA, 8'hCE, 8'h12, 8'hC5, 8'h53, 8'h15, 8'h5D, 8'h5F,
        8'h5E, 8'h4F, 8'h99
    };

    // Codes outside space to Z give a blank glyph.
    function automatic logic [7:0] glyph_lookup(input logic [7:0] c);
        logic [7:0] offset;
        offset = c - CHAR_SPACE;
        if (c < CHAR_SPACE || c > CHAR_Z) begin
            return 8'h00;
        end
        return GLYPH_TABLE[offset[5:0]];
    endfunction

endpackage

// ----- design/segment_lcd_text_encoder_core.sv -----
// A result passes through the execute stage and then the output register; further results of
// the same item follow one per cycle while m_ready holds. Throughput: one item per cycle while
// each item gives at most one result and m_ready holds; the execute stage keeps an item until
// the output register has taken all its results (two at most for a character, six for a fill).
// Reset: synchronous, active low; the state word reads as its reset value until first written.
// Top level of the segment LCD text encoder. Depends on design/slcd_pkg.sv.
module segment_lcd_text_encoder_core #(
    parameter int DIGITS = slcd_pkg::DIGITS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_command,
    input  logic [7:0] s_char_code,
    input  logic       s_first_char,
    input  logic [7:0] s_indicator_mask,
    input  logic       s_fill_on,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_position,
    output logic [7:0] m_segment_byte,
    output logic       m_last
);

    localparam int         FILL_COUNT = (DIGITS + 1 > slcd_pkg::MAX_RESULTS) ?
                                        slcd_pkg::MAX_RESULTS : DIGITS + 1;
    localparam logic [2:0] DIGIT_MAX  = 3'(DIGITS);
    localparam logic [2:0] FILL_N     = 3'(FILL_COUNT);

    // Single-word state memory, read at accept with registered data.
    slcd_pkg::state_t state_mem [1];
    logic             mem_init_reg;
    logic             mem_we;
    slcd_pkg::state_t rd_data_reg;
    logic             rd_init_reg;

    // Execute stage holding the item under work.
    logic       s1_valid_reg;
    logic [2:0] s1_cmd_reg;
    logic [7:0] s1_char_reg;
    logic       s1_first_reg;
    logic [7:0] s1_mask_reg;
    logic       s1_fill_reg;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;

    logic       m_valid_reg;
    logic [2:0] m_position_reg;
    logic [7:0] m_segment_byte_reg;
    logic       m_last_reg;

    slcd_pkg::state_t cur;
    slcd_pkg::state_t nxt;
    logic [2:0]       res_n;
    logic [2:0]       res_pos  [slcd_pkg::MAX_RESULTS];
    logic [7:0]       res_byte [slcd_pkg::MAX_RESULTS];
    logic [7:0]       upc;
    logic [7:0]       glyph;
    logic [2:0]       slot;
    logic [7:0]       fill_byte;
    logic             s_accept;
    logic             out_load;
    logic             final_res;
    logic             s1_done;

    assign cur = rd_init_reg ? rd_data_reg : slcd_pkg::STATE_RESET;

    always_comb begin
        nxt       = cur;
        res_n     = 3'd0;
        slot      = 3'd0;
        glyph     = 8'h00;
        fill_byte = s1_fill_reg ? slcd_pkg::ALL_ON : 8'h00;
        upc       = s1_char_reg;
        if (s1_char_reg >= slcd_pkg::CHAR_LOW_A && s1_char_reg <= slcd_pkg::CHAR_LOW_Z) begin
            upc = s1_char_reg - slcd_pkg::CHAR_SPACE;
        end
        for (int i = 0; i < slcd_pkg::MAX_RESULTS; i++) begin
            res_pos[i]  = 3'd0;
            res_byte[i] = 8'h00;
        end
        case (s1_cmd_reg)
            slcd_pkg::CMD_CHAR: begin
                if (s1_first_reg) begin
                    nxt.next_digit     = 3'd1;
                    nxt.minus_pending  = 1'b0;
                    nxt.point_pending  = 1'b0;
                    nxt.indicator_bits = cur.indicator_bits & ~slcd_pkg::COLON_BIT;
                    res_byte[0]        = nxt.indicator_bits;
                    res_n              = 3'd1;
                    slot               = 3'd1;
                end
                if (s1_first_reg && upc == slcd_pkg::CHAR_MINUS) begin
                    nxt.minus_pending = 1'b1;
                end else if (upc == slcd_pkg::CHAR_DOT) begin
                    nxt.point_pending = 1'b1;
                end else if (upc == slcd_pkg::CHAR_COLON) begin
                    // The colon only counts between the second and third digits.
                    if (nxt.next_digit == 3'd3) begin
                        nxt.indicator_bits = nxt.indicator_bits | slcd_pkg::COLON_BIT;
                        res_pos[slot]      = 3'd0;
                        res_byte[slot]     = nxt.indicator_bits;
                        res_n              = res_n + 3'd1;
                    end
                end else if (nxt.next_digit != 3'd0 && nxt.next_digit <= DIGIT_MAX) begin
                    glyph = slcd_pkg::glyph_lookup(upc);
                    if (nxt.point_pending || (nxt.minus_pending && nxt.next_digit == 3'd1)) begin
                        glyph = glyph | slcd_pkg::POINT_BIT;
                    end
                    res_pos[slot]     = nxt.next_digit;
                    res_byte[slot]    = glyph;
                    res_n             = res_n + 3'd1;
                    nxt.point_pending = 1'b0;
                    if (nxt.next_digit == 3'd1) begin
                        nxt.minus_pending = 1'b0;
                    end
                    nxt.next_digit = (nxt.next_digit >= DIGIT_MAX) ? 3'd0 :
                                     nxt.next_digit + 3'd1;
                end
            end
            slcd_pkg::CMD_SET: begin
                nxt.indicator_bits = cur.indicator_bits | s1_mask_reg;
                res_byte[0]        = nxt.indicator_bits;
                res_n              = 3'd1;
            end
            slcd_pkg::CMD_CLEAR: begin
                nxt.indicator_bits = cur.indicator_bits & ~s1_mask_reg;
                res_byte[0]        = nxt.indicator_bits;
                res_n              = 3'd1;
            end
            slcd_pkg::CMD_TOGGLE: begin
                nxt.indicator_bits = cur.indicator_bits ^ slcd_pkg::COLON_BIT;
                res_byte[0]        = nxt.indicator_bits;
                res_n              = 3'd1;
            end
            slcd_pkg::CMD_FILL: begin
                nxt.indicator_bits = fill_byte;
                res_n              = FILL_N;
                for (int i = 0; i < slcd_pkg::MAX_RESULTS; i++) begin
                    res_pos[i]  = 3'(i);
                    res_byte[i] = fill_byte;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_load  = s1_valid_reg && res_n != 3'd0 && (!m_valid_reg || m_ready);
    assign final_res = idx_reg == res_n - 3'd1;
    assign s1_done   = s1_valid_reg && (res_n == 3'd0 || (out_load && final_res));
    assign s_ready   = !s1_valid_reg || s1_done;
    assign s_accept  = s_valid && s_ready;
    assign mem_we    = s1_done;

    always_comb begin
        idx_next = idx_reg;
        if (s1_done) begin
            idx_next = 3'd0;
        end else if (out_load) begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            state_mem[0] <= nxt;
        end
        // A write in the same cycle is forwarded to the new item.
        if (s_accept) begin
            rd_data_reg <= mem_we ? nxt : state_mem[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_init_reg <= 1'b0;
            rd_init_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            idx_reg      <= 3'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (mem_we) begin
                mem_init_reg <= 1'b1;
            end
            if (s_accept) begin
                rd_init_reg <= mem_init_reg || mem_we;
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_done) begin
                s1_valid_reg <= 1'b0;
            end
            idx_reg <= idx_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg   <= s_command;
            s1_char_reg  <= s_char_code;
            s1_first_reg <= s_first_char;
            s1_mask_reg  <= s_indicator_mask;
            s1_fill_reg  <= s_fill_on;
        end
        if (out_load) begin
            m_position_reg     <= res_pos[idx_reg];
            m_segment_byte_reg <= res_byte[idx_reg];
            m_last_reg         <= final_res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_position     = m_position_reg;
    assign m_segment_byte = m_segment_byte_reg;
    assign m_last         = m_last_reg;

    a_write_needs_item : assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> s1_valid_reg)
        else $error("state written without an item in the execute stage");

    a_idx_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && res_n != 3'd0 |-> idx_reg < res_n)
        else $error("result index beyond the item's result count");

    a_digit_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> cur.next_digit <= DIGIT_MAX)
        else $error("next digit beyond the display");

    a_position_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_position_reg <= DIGIT_MAX)
        else $error("result position beyond the display");

endmodule

// ----- verif/segment_lcd_text_encoder_core_tb.sv -----
// Self-checking testbench for segment_lcd_text_encoder_core: directed table, then random text.
// Depends on design/slcd_pkg.sv and design/segment_lcd_text_encoder_core.sv.
module segment_lcd_text_encoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS        = slcd_pkg::DIGITS_DEFAULT;
    localparam int MAX_RESULTS   = slcd_pkg::MAX_RESULTS;
    localparam int TOTAL_ITEMS   = 370;
    localparam int DIR_ROWS      = 27;
    localparam int RANDOM_ITEMS  = TOTAL_ITEMS - DIR_ROWS;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PREDICTED     = -1;
    localparam int COLON_DIGIT   = 3;

    localparam logic [2:0] CMD_CHAR   = slcd_pkg::CMD_CHAR;
    localparam logic [2:0] CMD_SET    = slcd_pkg::CMD_SET;
    localparam logic [2:0] CMD_CLEAR  = slcd_pkg::CMD_CLEAR;
    localparam logic [2:0] CMD_TOGGLE = slcd_pkg::CMD_TOGGLE;
    localparam logic [2:0] CMD_FILL   = slcd_pkg::CMD_FILL;
    localparam logic [2:0] CMD_RSVD5  = 3'd5;
    localparam logic [2:0] CMD_RSVD6  = 3'd6;
    localparam logic [2:0] CMD_RSVD7  = 3'd7;

    localparam logic [7:0] COLON_BIT  = slcd_pkg::COLON_BIT;
    localparam logic [7:0] POINT_BIT  = slcd_pkg::POINT_BIT;
    localparam logic [7:0] ALL_ON     = slcd_pkg::ALL_ON;
    localparam logic [7:0] CHAR_SPACE = slcd_pkg::CHAR_SPACE;
    localparam logic [7:0] CHAR_Z     = slcd_pkg::CHAR_Z;
    localparam logic [7:0] CHAR_LOW_A = slcd_pkg::CHAR_LOW_A;
    localparam logic [7:0] CHAR_LOW_Z = slcd_pkg::CHAR_LOW_Z;
    localparam logic [7:0] CHAR_MINUS = slcd_pkg::CHAR_MINUS;
    localparam logic [7:0] CHAR_DOT   = slcd_pkg::CHAR_DOT;
    localparam logic [7:0] CHAR_COLON = slcd_pkg::CHAR_COLON;

    localparam logic [7:0] CASE_SHIFT = 8'd32;
    localparam logic [7:0] CHAR_ZERO  = "0";
    localparam logic [7:0] CHAR_UP_A  = "A";

    localparam logic [7:0] SEG_GLYPHS [59] = '{
        8'h00, 8'h2C, 8'h48, 8'hCA, 8'h55, 8'h44, 8'hD8, 8'h08,
        8'hD1, 8'h8D, 8'h00, 8'h52, 8'h04, 8'h02, 8'h20, 8'h0C,
        8'hDD, 8'h0C, 8'h9B, 8'h8F, 8'h4E, 8'hC7, 8'hD7, 8'hCC,
        8'hDF, 8'hCF, 8'h00, 8'h40, 8'h11, 8'h03, 8'h05, 8'h9A,
        8'hFF, 8'hDE, 8'h57, 8'h13, 8'h1F, 8'hD3, 8'hD2, 8'hCF,
        8'h56, 8'h10, 8'h1D, 8'hD6, 8'h51, 8'hDC, 8'h16, 8'h17,
        8'hDA, 8'hCE, 8'h12, 8'hC5, 8'h53, 8'h15, 8'h5D, 8'h5F,
        8'h5E, 8'h4F, 8'h99
    };

    typedef slcd_pkg::state_t state_t;

    typedef struct packed {
        logic [2:0] position;
        logic [7:0] segment_byte;
        logic       last;
    } seg_result_t;

    // One input item; n_typed gives how many results are written out by hand below,
    // or PREDICTED where the predictor supplies them.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] ch;
        logic       first;
        logic [7:0] mask;
        logic       fill;
        int         n_typed;
        logic [2:0] p0;
        logic [7:0] b0;
        logic [2:0] p1;
        logic [7:0] b1;
    } stim_row_t;

    typedef enum int {RX_OPEN, RX_ALTERNATE, RX_COIN, RX_STALLS} rx_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_command;
    logic [7:0] s_char_code;
    logic       s_first_char;
    logic [7:0] s_indicator_mask;
    logic       s_fill_on;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_position;
    logic [7:0] m_segment_byte;
    logic       m_last;

    state_t      disp;
    seg_result_t predicted [MAX_RESULTS];
    int          predicted_n;
    seg_result_t pending_segments [$];
    int          errors;
    int          burst_left;
    int          string_left;
    int          idle_cycles;
    rx_mode_t    rx_mode;
    int          rx_phase_left;
    int          rx_hold;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_CLEAR,  8'h00,      1'b0, 8'hFF, 1'b0, 1, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_SET,    8'h00,      1'b0, 8'hFF, 1'b0, 1, 3'd0, 8'hFF, 3'd0, 8'h00},
        '{CMD_CLEAR,  8'hFF,      1'b0, 8'h0F, 1'b1, 1, 3'd0, 8'hF0, 3'd0, 8'h00},
        '{CMD_TOGGLE, 8'h00,      1'b0, 8'h00, 1'b0, 1, 3'd0, 8'hE0, 3'd0, 8'h00},
        '{CMD_SET,    8'h00,      1'b0, 8'h00, 1'b0, 1, 3'd0, 8'hE0, 3'd0, 8'h00},
        '{CMD_FILL,   8'h00,      1'b0, 8'h00, 1'b1, PREDICTED, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_FILL,   8'hFF,      1'b1, 8'hFF, 1'b0, PREDICTED, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_RSVD5,  8'h00,      1'b0, 8'h00, 1'b0, 0, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_RSVD6,  8'hFF,      1'b1, 8'hFF, 1'b1, 0, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_RSVD7,  CHAR_MINUS, 1'b1, 8'h00, 1'b0, 0, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   CHAR_MINUS, 1'b1, 8'h00, 1'b0, 1, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   "1",        1'b0, 8'h00, 1'b0, PREDICTED, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   "2",        1'b0, 8'h00, 1'b0, PREDICTED, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   CHAR_COLON, 1'b0, 8'h00, 1'b0, 1, 3'd0, 8'h10, 3'd0, 8'h00},
        '{CMD_CHAR,   CHAR_DOT,   1'b0, 8'h00, 1'b0, 0, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   "a",        1'b0, 8'h00, 1'b0, PREDICTED, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   "z",        1'b0, 8'h00, 1'b0, PREDICTED, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   8'h00,      1'b0, 8'h00, 1'b0, 1, 3'd5, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   "X",        1'b0, 8'h00, 1'b0, 0, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   CHAR_DOT,   1'b0, 8'h00, 1'b0, 0, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   "Z",        1'b1, 8'h00, 1'b0, PREDICTED, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   8'hFF,      1'b1, 8'h00, 1'b0, 2, 3'd0, 8'h00, 3'd1, 8'h00},
        '{CMD_CHAR,   CHAR_COLON, 1'b1, 8'h00, 1'b0, 1, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   CHAR_DOT,   1'b1, 8'h00, 1'b0, 1, 3'd0, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   "{",        1'b0, 8'h00, 1'b0, 1, 3'd1, 8'h20, 3'd0, 8'h00},
        '{CMD_CHAR,   " ",        1'b0, 8'h00, 1'b0, 1, 3'd2, 8'h00, 3'd0, 8'h00},
        '{CMD_CHAR,   CHAR_MINUS, 1'b0, 8'h00, 1'b0, PREDICTED, 3'd0, 8'h00, 3'd0, 8'h00}
    };

    segment_lcd_text_encoder_core #(
        .DIGITS(DIGITS)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_char_code      (s_char_code),
        .s_first_char     (s_first_char),
        .s_indicator_mask (s_indicator_mask),
        .s_fill_on        (s_fill_on),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position       (m_position),
        .m_segment_byte   (m_segment_byte),
        .m_last           (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("ERROR at %0t ns: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
        errors++;
    endtask

    function automatic void add_segment(input logic [2:0] pos, input logic [7:0] seg);
        if (predicted_n < MAX_RESULTS) begin
            predicted[predicted_n] = '{position: pos, segment_byte: seg, last: 1'b0};
            predicted_n++;
        end
    endfunction

    // Works out the segment bytes an item causes and advances the display state.
    function automatic void predict_segments(input stim_row_t it);
        logic [7:0] c;
        logic [7:0] g;
        logic [7:0] off;
        logic       glyph_taken;
        predicted_n = 0;
        glyph_taken = 1'b0;
        case (it.cmd)
            CMD_CHAR: begin
                c = it.ch;
                if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
                    c = c - CASE_SHIFT;
                end
                if (it.first) begin
                    disp.next_digit = 3'd1;
                    disp.minus_pending = 1'b0;
                    disp.point_pending = 1'b0;
                    disp.indicator_bits = disp.indicator_bits & ~COLON_BIT;
                    add_segment(3'd0, disp.indicator_bits);
                    // A leading minus only arms the point of digit one.
                    if (c == CHAR_MINUS) begin
                        disp.minus_pending = 1'b1;
                        glyph_taken = 1'b1;
                    end
                end
                if (!glyph_taken) begin
                    if (c == CHAR_DOT) begin
                        disp.point_pending = 1'b1;
                    end else if (c == CHAR_COLON) begin
                        if (disp.next_digit == COLON_DIGIT) begin
                            disp.indicator_bits = disp.indicator_bits | COLON_BIT;
                            add_segment(3'd0, disp.indicator_bits);
                        end
                    end else if (disp.next_digit != 3'd0 && disp.next_digit <= DIGITS) begin
                        off = c - CHAR_SPACE;
                        if (c < CHAR_SPACE || c > CHAR_Z) begin
                            g = 8'h00;
                        end else begin
                            g = SEG_GLYPHS[off[5:0]];
                        end
                        if (disp.point_pending ||
                            (disp.minus_pending && disp.next_digit == 3'd1)) begin
                            g = g | POINT_BIT;
                        end
                        add_segment(disp.next_digit, g);
                        disp.point_pending = 1'b0;
                        if (disp.next_digit == 3'd1) begin
                            disp.minus_pending = 1'b0;
                        end
                        disp.next_digit = (disp.next_digit >= DIGITS) ? 3'd0 :
                                          disp.next_digit + 3'd1;
                    end
                end
            end
            CMD_SET: begin
                disp.indicator_bits = disp.indicator_bits | it.mask;
                add_segment(3'd0, disp.indicator_bits);
            end
            CMD_CLEAR: begin
                disp.indicator_bits = disp.indicator_bits & ~it.mask;
                add_segment(3'd0, disp.indicator_bits);
            end
            CMD_TOGGLE: begin
                disp.indicator_bits = disp.indicator_bits ^ COLON_BIT;
                add_segment(3'd0, disp.indicator_bits);
            end
            CMD_FILL: begin
                disp.indicator_bits = it.fill ? ALL_ON : 8'h00;
                for (int p = 0; p <= DIGITS && p < MAX_RESULTS; p++) begin
                    add_segment(3'(p), it.fill ? ALL_ON : 8'h00);
                end
            end
            default: begin
            end
        endcase
        if (predicted_n > 0) begin
            predicted[predicted_n - 1].last = 1'b1;
        end
    endfunction

    function automatic logic [7:0] pick_text_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return CHAR_ZERO + 8'($urandom_range(0, 9));
            3, 4:    return CHAR_UP_A + 8'($urandom_range(0, 25));
            5:       return CHAR_LOW_A + 8'($urandom_range(0, 25));
            6:       return CHAR_DOT;
            7:       return CHAR_COLON;
            8:       return CHAR_MINUS;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed strings with random text, mixed with indicator commands,
    // the odd fill and some fully random noise.
    function automatic stim_row_t next_random_item();
        stim_row_t it;
        int        pick;
        it = '0;
        it.cmd = CMD_CHAR;
        it.ch = 8'($urandom_range(0, 255));
        it.mask = 8'($urandom_range(0, 255));
        it.fill = 1'($urandom_range(0, 1));
        it.n_typed = PREDICTED;
        if (string_left > 0) begin
            string_left--;
            it.ch = pick_text_char();
        end else begin
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                string_left = $urandom_range(0, 7);
                it.first = 1'b1;
                it.ch = pick_text_char();
            end else if (pick < 16) begin
                it.cmd = 3'($urandom_range(CMD_SET, CMD_TOGGLE));
            end else if (pick == 16) begin
                it.cmd = CMD_FILL;
            end else begin
                it.cmd = 3'($urandom_range(0, 7));
                it.first = 1'($urandom_range(0, 1));
            end
        end
        return it;
    endfunction

    task automatic drive_item(input stim_row_t it);
        seg_result_t r;
        int          gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_valid          <= 1'b1;
        s_command        <= it.cmd;
        s_char_code      <= it.ch;
        s_first_char     <= it.first;
        s_indicator_mask <= it.mask;
        s_fill_on        <= it.fill;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_segments(it);
        if (it.n_typed == PREDICTED) begin
            for (int k = 0; k < predicted_n; k++) begin
                pending_segments.push_back(predicted[k]);
            end
        end else begin
            for (int k = 0; k < it.n_typed; k++) begin
                r.position = (k == 0) ? it.p0 : it.p1;
                r.segment_byte = (k == 0) ? it.b0 : it.b1;
                r.last = (k == it.n_typed - 1);
                pending_segments.push_back(r);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_phase_left = 0;
            rx_hold = 0;
        end else begin
            if (rx_phase_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_phase_left = $urandom_range(20, 80);
            end
            rx_phase_left--;
            case (rx_mode)
                RX_OPEN:      m_ready <= 1'b1;
                RX_ALTERNATE: m_ready <= rx_phase_left[0];
                RX_COIN:      m_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (rx_hold > 0) begin
                        rx_hold--;
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0) begin
                            rx_hold = $urandom_range(1, 10);
                        end
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin : result_monitor
        seg_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_segments.size() == 0) begin
                report_mismatch("result with none pending, position", 0, int'(m_position));
            end else begin
                want = pending_segments.pop_front();
                if (m_position !== want.position) begin
                    report_mismatch("position", int'(want.position), int'(m_position));
                end
                if (m_segment_byte !== want.segment_byte) begin
                    report_mismatch("segment_byte", int'(want.segment_byte),
                                    int'(m_segment_byte));
                end
                if (m_last !== want.last) begin
                    report_mismatch("last", int'(want.last), int'(m_last));
                end
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        burst_left = 0;
        string_left = 0;
        idle_cycles = 0;
        disp = slcd_pkg::STATE_RESET;
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_command        <= CMD_CHAR;
        s_char_code      <= 8'h00;
        s_first_char     <= 1'b0;
        s_indicator_mask <= 8'h00;
        s_fill_on        <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            drive_item(dir_rows[i]);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            drive_item(next_random_item());
        end
        s_valid <= 1'b0;

        while (pending_segments.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
